>>> rtl/slfd_pkg.sv
// shared types, constants and lookup functions for the sync/length frame deframer
// no dependencies; used by every module of the block except slfd_ram
package slfd_pkg;

   // default upper bound on the payload length of one frame
   localparam int MAX_PAYLOAD_DEF = 20;
   // width of the length field carried in a frame descriptor (covers up to 63)
   localparam int DESC_LEN_W = 6;
   // frame descriptor queue depth
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0]  SYNC_X         = 8'h58;
   localparam logic [7:0]  SYNC_M         = 8'h4D;
   localparam logic [7:0]  SYNC_S         = 8'h53;
   localparam logic [23:0] SYNC_KEYBOARD  = 24'h584D53;
   localparam logic [23:0] SYNC_MAINBOARD = 24'h58534D;
   localparam logic [15:0] SET_KEY_CHECK  = 16'd362;
   localparam int          NO_KEY_LEN     = 10;

   // configuration register indexes
   localparam logic REG_SET_KEY_LOCK        = 1'b0;
   localparam logic REG_SUPPRESS_DUPLICATES = 1'b1;

   typedef struct packed {
      logic                  kb;
      logic                  too_long;
      logic                  dup;
      logic                  rep;
      logic [DESC_LEN_W-1:0] len;
      logic [15:0]           check;
   } frame_desc_type;

   // fixed no-key frame sent in place of a keyboard set frame
   function automatic logic [7:0] no_key_byte(input logic [3:0] idx);
      logic [7:0] b;
      case (idx)
         4'd0:    b = 8'h58;
         4'd1:    b = 8'h4D;
         4'd2:    b = 8'h53;
         4'd3:    b = 8'h00;
         4'd4:    b = 8'h03;
         4'd5:    b = 8'h6B;
         4'd6:    b = 8'h00;
         4'd7:    b = 8'h00;
         4'd8:    b = 8'h01;
         4'd9:    b = 8'h66;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

>>> rtl/slfd_ram.sv
// generic single write port / single read port ram with registered read data
// no dependencies
module slfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 40
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/slfd_front.sv
// front end: sync hunt, length and check parsing, payload capture, descriptor build
// depends on slfd_pkg
module slfd_front #(
   parameter int MAX_PAYLOAD = slfd_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           byte_accept,
   input  logic [7:0]                     rx_byte,
   input  logic                           set_key_lock,
   input  logic                           suppress_duplicates,
   input  logic                           wr_bank,
   output logic                           ram_wr_en,
   output logic [$clog2(2*MAX_PAYLOAD)-1:0] ram_wr_addr,
   output logic                           push,
   output slfd_pkg::frame_desc_type       push_desc
);

   localparam int LW = $clog2(MAX_PAYLOAD + 1);
   localparam int AW = $clog2(2 * MAX_PAYLOAD);
   localparam int DW = slfd_pkg::DESC_LEN_W;

   localparam logic [2:0] PH_HUNT    = 3'd0;
   localparam logic [2:0] PH_LEN_HI  = 3'd1;
   localparam logic [2:0] PH_LEN_LO  = 3'd2;
   localparam logic [2:0] PH_PAYLOAD = 3'd3;
   localparam logic [2:0] PH_CHK_HI  = 3'd4;
   localparam logic [2:0] PH_CHK_LO  = 3'd5;

   logic [2:0]    phase_ff, phase_in;
   logic [23:0]   window_ff, window_in;
   logic          kb_ff, kb_in;
   logic [7:0]    len_hi_ff, len_hi_in;
   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] count_ff, count_in;
   logic [7:0]    chk_hi_ff, chk_hi_in;
   logic [15:0]   last_kb_ff, last_kb_in;
   logic [15:0]   last_mb_ff, last_mb_in;

   logic [23:0] window_next;
   logic [15:0] check_full;
   logic        too_long;

   assign window_next = {window_ff[15:0], rx_byte};
   assign check_full  = {chk_hi_ff, rx_byte};
   assign too_long    = (len_hi_ff != 8'd0) || ({1'b0, rx_byte} > 9'(MAX_PAYLOAD));

   assign ram_wr_en   = byte_accept && (phase_ff == PH_PAYLOAD);
   assign ram_wr_addr = (wr_bank ? AW'(MAX_PAYLOAD) : AW'(0)) + AW'(count_ff);

   always_comb begin
      phase_in   = phase_ff;
      window_in  = window_ff;
      kb_in      = kb_ff;
      len_hi_in  = len_hi_ff;
      len_in     = len_ff;
      count_in   = count_ff;
      chk_hi_in  = chk_hi_ff;
      last_kb_in = last_kb_ff;
      last_mb_in = last_mb_ff;
      push       = 1'b0;
      push_desc  = '0;
      push_desc.kb = kb_ff;
      if (byte_accept) begin
         unique case (phase_ff)
            PH_LEN_HI: begin
               len_hi_in = rx_byte;
               phase_in  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               if (too_long) begin
                  len_in             = '0;
                  phase_in           = PH_HUNT;
                  push               = 1'b1;
                  push_desc.too_long = 1'b1;
               end else begin
                  len_in   = LW'(rx_byte);
                  count_in = '0;
                  phase_in = (rx_byte == 8'd0) ? PH_CHK_HI : PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               count_in = count_ff + LW'(1);
               if (count_in >= len_ff) begin
                  phase_in = PH_CHK_HI;
               end
            end
            PH_CHK_HI: begin
               chk_hi_in = rx_byte;
               phase_in  = PH_CHK_LO;
            end
            PH_CHK_LO: begin
               push            = 1'b1;
               push_desc.len   = DW'(len_ff);
               push_desc.check = check_full;
               if (kb_ff) begin
                  push_desc.dup = suppress_duplicates && (check_full == last_kb_ff);
                  last_kb_in    = check_full;
               end else begin
                  push_desc.dup = suppress_duplicates && (check_full == last_mb_ff);
                  last_mb_in    = check_full;
               end
               push_desc.rep = set_key_lock && kb_ff &&
                               (check_full == slfd_pkg::SET_KEY_CHECK);
               phase_in = PH_HUNT;
            end
            default: begin
               window_in = window_next;
               if ((window_next == slfd_pkg::SYNC_KEYBOARD) ||
                   (window_next == slfd_pkg::SYNC_MAINBOARD)) begin
                  kb_in     = (window_next == slfd_pkg::SYNC_KEYBOARD);
                  window_in = '0;
                  len_hi_in = '0;
                  phase_in  = PH_LEN_HI;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         window_ff  <= '0;
         kb_ff      <= 1'b0;
         len_hi_ff  <= '0;
         len_ff     <= '0;
         count_ff   <= '0;
         last_kb_ff <= '0;
         last_mb_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         window_ff  <= window_in;
         kb_ff      <= kb_in;
         len_hi_ff  <= len_hi_in;
         len_ff     <= len_in;
         count_ff   <= count_in;
         last_kb_ff <= last_kb_in;
         last_mb_ff <= last_mb_in;
      end
      chk_hi_ff <= chk_hi_in;
   end

endmodule

>>> rtl/slfd_queue.sv
// two-entry frame descriptor queue; entry slot doubles as payload buffer bank
// depends on slfd_pkg
module slfd_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  slfd_pkg::frame_desc_type push_desc,
   input  logic                     pop,
   output slfd_pkg::frame_desc_type head_desc,
   output logic                     empty,
   output logic                     full,
   output logic                     wr_bank,
   output logic                     rd_bank
);

   slfd_pkg::frame_desc_type slot_ff [slfd_pkg::QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign empty     = (count_ff == 2'd0);
   assign full      = (count_ff == 2'(slfd_pkg::QUEUE_DEPTH));
   assign head_desc = slot_ff[rd_ptr_ff];
   assign wr_bank   = wr_ptr_ff;
   assign rd_bank   = rd_ptr_ff;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + (push ? 2'd1 : 2'd0) - (pop ? 2'd1 : 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

>>> rtl/slfd_back.sv
// back end: replays one queued frame byte by byte into the result register
// depends on slfd_pkg
module slfd_back #(
   parameter int MAX_PAYLOAD = slfd_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  slfd_pkg::frame_desc_type         head_desc,
   input  logic                             empty,
   input  logic                             rd_bank,
   output logic                             pop,
   output logic [$clog2(2*MAX_PAYLOAD)-1:0] ram_rd_addr,
   input  logic [7:0]                       ram_rd_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [7:0]                       rsp_out_byte,
   output logic                             rsp_last_byte,
   output logic                             rsp_from_keyboard,
   output logic [$clog2(MAX_PAYLOAD+1)-1:0] rsp_payload_length,
   output logic [15:0]                      rsp_check_value,
   output logic                             rsp_duplicate,
   output logic                             rsp_replaced,
   output logic                             rsp_too_long
);

   localparam int LW = $clog2(MAX_PAYLOAD + 1);
   localparam int AW = $clog2(2 * MAX_PAYLOAD);
   localparam int IW = (MAX_PAYLOAD + 7 > 10) ? $clog2(MAX_PAYLOAD + 7) : 4;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FETCH = 2'd1;
   localparam logic [1:0] ST_SEND  = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic          valid_ff, valid_in;
   logic [7:0]    byte_ff, byte_in;
   logic          last_ff, last_in;
   logic          kb_ff;
   logic [LW-1:0] len_ff;
   logic [15:0]   check_ff;
   logic          dup_ff, rep_ff, tl_ff;

   logic          out_free;
   logic          load;
   logic [IW-1:0] len_i;
   logic [IW-1:0] last_idx;
   logic [IW-1:0] pay_off;
   logic [7:0]    sel_byte;
   logic          is_last;

   assign out_free = !valid_ff || !rsp_stall;
   assign len_i    = IW'(head_desc.len);
   assign pay_off  = idx_ff - IW'(5);
   assign ram_rd_addr = (rd_bank ? AW'(MAX_PAYLOAD) : AW'(0)) + AW'(pay_off);

   always_comb begin
      if (head_desc.too_long) begin
         last_idx = '0;
      end else if (head_desc.rep) begin
         last_idx = IW'(slfd_pkg::NO_KEY_LEN - 1);
      end else begin
         last_idx = len_i + IW'(6);
      end
      is_last = (idx_ff == last_idx);

      if (head_desc.too_long) begin
         sel_byte = 8'h00;
      end else if (head_desc.rep) begin
         sel_byte = slfd_pkg::no_key_byte(idx_ff[3:0]);
      end else if (idx_ff == IW'(0)) begin
         sel_byte = slfd_pkg::SYNC_X;
      end else if (idx_ff == IW'(1)) begin
         sel_byte = head_desc.kb ? slfd_pkg::SYNC_M : slfd_pkg::SYNC_S;
      end else if (idx_ff == IW'(2)) begin
         sel_byte = head_desc.kb ? slfd_pkg::SYNC_S : slfd_pkg::SYNC_M;
      end else if (idx_ff == IW'(3)) begin
         sel_byte = 8'h00;
      end else if (idx_ff == IW'(4)) begin
         sel_byte = 8'(head_desc.len);
      end else if (idx_ff < len_i + IW'(5)) begin
         sel_byte = ram_rd_data;
      end else if (idx_ff == len_i + IW'(5)) begin
         sel_byte = head_desc.check[15:8];
      end else begin
         sel_byte = head_desc.check[7:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      load     = 1'b0;
      pop      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               idx_in   = '0;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (out_free) begin
               load = 1'b1;
               if (is_last) begin
                  pop      = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + IW'(1);
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
      byte_in = load ? sel_byte : byte_ff;
      last_in = load ? is_last : last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
      last_ff <= last_in;
      if (load) begin
         kb_ff    <= head_desc.kb;
         len_ff   <= LW'(head_desc.len);
         check_ff <= head_desc.check;
         dup_ff   <= head_desc.dup;
         rep_ff   <= head_desc.rep;
         tl_ff    <= head_desc.too_long;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_out_byte       = byte_ff;
   assign rsp_last_byte      = last_ff;
   assign rsp_from_keyboard  = kb_ff;
   assign rsp_payload_length = len_ff;
   assign rsp_check_value    = check_ff;
   assign rsp_duplicate      = dup_ff;
   assign rsp_replaced       = rep_ff;
   assign rsp_too_long       = tl_ff;

endmodule

>>> rtl/sync_length_frame_deframer_top.sv
// top level of the sync/length frame deframer: register port and front/queue/back wiring
// depends on slfd_pkg, slfd_ram, slfd_front, slfd_queue, slfd_back
//
// Received bytes enter one per transfer on the req_ channel. The front end hunts for
// the sync word XMS (keyboard) or XSM (mainboard), reads a big-endian 16-bit length,
// the payload and a 16-bit check word, and writes the payload into one of two ram
// banks. Each completed frame (or a single too_long marker when the length is above
// MAX_PAYLOAD) is queued as a descriptor; the back end replays it on the rsp_ channel,
// one transfer per byte, with last_byte on the final one. Input bytes are taken as
// long as the queue holds fewer than two frames (the frame in replay counts until
// its last byte is loaded into the result register); the replay picks up the
// descriptor, then for each result byte reads the ram and then loads the result
// register, holding while the output is stalled. The result register lets the next
// byte be fetched while the current one waits to be taken. Registers: set_key_lock
// at 0x0, suppress_duplicates at 0x4; write them only while idle.
module sync_length_frame_deframer_top #(
   parameter int MAX_PAYLOAD = slfd_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // input byte channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_rx_byte,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [7:0]                       rsp_out_byte,
   output logic                             rsp_last_byte,
   output logic                             rsp_from_keyboard,
   output logic [$clog2(MAX_PAYLOAD+1)-1:0] rsp_payload_length,
   output logic [15:0]                      rsp_check_value,
   output logic                             rsp_duplicate,
   output logic                             rsp_replaced,
   output logic                             rsp_too_long,
   // register port
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [2:0]                       paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);

   localparam int AW = $clog2(2 * MAX_PAYLOAD);

   logic lock_ff, lock_in;
   logic supp_ff, supp_in;
   logic reg_write;

   logic                     byte_accept;
   logic                     ram_wr_en;
   logic [AW-1:0]            ram_wr_addr;
   logic [AW-1:0]            ram_rd_addr;
   logic [7:0]               ram_rd_data;
   logic                     push, pop;
   slfd_pkg::frame_desc_type push_desc, head_desc;
   logic                     q_empty, q_full;
   logic                     wr_bank, rd_bank;

   // register port: always ready, register index taken from paddr[2]
   assign pready    = 1'b1;
   assign reg_write = psel && penable && pwrite;

   always_comb begin
      lock_in = lock_ff;
      supp_in = supp_ff;
      if (reg_write) begin
         unique case (paddr[2])
            slfd_pkg::REG_SET_KEY_LOCK:        lock_in = pwdata[0];
            slfd_pkg::REG_SUPPRESS_DUPLICATES: supp_in = pwdata[0];
            default:                           lock_in = lock_ff;
         endcase
      end
      unique case (paddr[2])
         slfd_pkg::REG_SET_KEY_LOCK:        prdata = {31'd0, lock_ff};
         slfd_pkg::REG_SUPPRESS_DUPLICATES: prdata = {31'd0, supp_ff};
         default:                           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lock_ff <= 1'b0;
         supp_ff <= 1'b1;
      end else begin
         lock_ff <= lock_in;
         supp_ff <= supp_in;
      end
   end

   // input stalls only while both payload banks hold frames not yet fully replayed
   assign req_stall   = q_full;
   assign byte_accept = req_valid && !q_full;

   slfd_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .byte_accept         (byte_accept),
      .rx_byte             (req_rx_byte),
      .set_key_lock        (lock_ff),
      .suppress_duplicates (supp_ff),
      .wr_bank             (wr_bank),
      .ram_wr_en           (ram_wr_en),
      .ram_wr_addr         (ram_wr_addr),
      .push                (push),
      .push_desc           (push_desc)
   );

   // payload buffer: two banks of MAX_PAYLOAD bytes, bank chosen by queue slot
   slfd_ram #(
      .WIDTH (8),
      .DEPTH (2 * MAX_PAYLOAD)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_rx_byte),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   slfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head_desc (head_desc),
      .empty     (q_empty),
      .full      (q_full),
      .wr_bank   (wr_bank),
      .rd_bank   (rd_bank)
   );

   slfd_back #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .head_desc          (head_desc),
      .empty              (q_empty),
      .rd_bank            (rd_bank),
      .pop                (pop),
      .ram_rd_addr        (ram_rd_addr),
      .ram_rd_data        (ram_rd_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last_byte      (rsp_last_byte),
      .rsp_from_keyboard  (rsp_from_keyboard),
      .rsp_payload_length (rsp_payload_length),
      .rsp_check_value    (rsp_check_value),
      .rsp_duplicate      (rsp_duplicate),
      .rsp_replaced       (rsp_replaced),
      .rsp_too_long       (rsp_too_long)
   );

endmodule
